### rtl/i2r_pkg.sv
// ============================================================================
// i2r_pkg: shared types, codes and letter tables
// Status codes, the classified item passed from front to back, and the
// digit pattern and letter decoders used to spell out each decimal place.
// ============================================================================
package i2r_pkg;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_RANGE = 2'd2
    } status_t;

    // letter selector inside one digit pattern
    typedef enum logic [1:0] {
        SEL_ONE  = 2'd0,
        SEL_FIVE = 2'd1,
        SEL_TEN  = 2'd2
    } sel_t;

    typedef logic [3:0] digit_t;
    typedef logic [1:0] place_t;   // 0 thousands .. 3 units
    typedef logic [1:0] pos_t;     // character within a digit pattern

    typedef struct packed {
        status_t        status;
        digit_t [3:0]   digits;    // digits[0] is the thousands place
    } item_t;

    localparam logic [11:0] MAX_VALUE = 12'd3999;

    localparam logic [6:0] ASCII_M = 7'h4D;
    localparam logic [6:0] ASCII_D = 7'h44;
    localparam logic [6:0] ASCII_C = 7'h43;
    localparam logic [6:0] ASCII_L = 7'h4C;
    localparam logic [6:0] ASCII_X = 7'h58;
    localparam logic [6:0] ASCII_V = 7'h56;
    localparam logic [6:0] ASCII_I = 7'h49;

    // number of letters a decimal digit spells
    function automatic logic [2:0] pattern_len(input digit_t d);
        logic [2:0] len;
        begin
            unique case (d) inside
                4'd1, 4'd5:       len = 3'd1;
                4'd2, 4'd4, 4'd6,
                4'd9:             len = 3'd2;
                4'd3, 4'd7:       len = 3'd3;
                4'd8:             len = 3'd4;
                default:          len = 3'd0;
            endcase
            return len;
        end
    endfunction

    // which of one, five, ten letters sits at position pos of digit d
    function automatic sel_t pattern_sel(input digit_t d, input pos_t pos);
        sel_t sel;
        begin
            unique case (d) inside
                4'd4:                   sel = (pos == 2'd0) ? SEL_ONE : SEL_FIVE;
                4'd5, 4'd6, 4'd7, 4'd8: sel = (pos == 2'd0) ? SEL_FIVE : SEL_ONE;
                4'd9:                   sel = (pos == 2'd0) ? SEL_ONE : SEL_TEN;
                default:                sel = SEL_ONE;
            endcase
            return sel;
        end
    endfunction

    function automatic logic [6:0] place_letter(input place_t place, input sel_t sel);
        logic [6:0] letter;
        begin
            unique case (place)
                2'd0: letter = ASCII_M;
                2'd1: letter = (sel == SEL_ONE) ? ASCII_C :
                               (sel == SEL_FIVE) ? ASCII_D : ASCII_M;
                2'd2: letter = (sel == SEL_ONE) ? ASCII_X :
                               (sel == SEL_FIVE) ? ASCII_L : ASCII_C;
                default: letter = (sel == SEL_ONE) ? ASCII_I :
                                  (sel == SEL_FIVE) ? ASCII_V : ASCII_X;
            endcase
            return letter;
        end
    endfunction

endpackage

### rtl/i2r_front.sv
// ============================================================================
// i2r_front: input stage and decimal split
// Accept a value, classify it and register the thousands split; split the
// remainder into hundreds, tens and units on the way into the queue.
// ============================================================================
module i2r_front
    import i2r_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [11:0] value,
    output logic        push_valid,
    output item_t       push_item,
    input  logic        queue_full
);

    logic        s1_valid_reg, s1_valid_next;
    status_t     s1_status_reg;
    digit_t      s1_thou_reg;
    logic [9:0]  s1_rem_reg;

    status_t     status_c;
    digit_t      thou_c;
    logic [11:0] thou_sub;
    logic        accept;
    digit_t      hund_c, tens_c, unit_c;
    logic [9:0]  rem_h;
    logic [6:0]  rem_t;
    logic [6:0]  tens_sub;

    assign req_stall  = s1_valid_reg && queue_full;
    assign accept     = req_valid && !req_stall;
    assign push_valid = s1_valid_reg;

    // classify and take off the thousands
    always_comb
    begin
        if (value == 12'd0)
            status_c = STATUS_EMPTY;
        else if (value > MAX_VALUE)
            status_c = STATUS_RANGE;
        else
            status_c = STATUS_OK;

        if (value >= 12'd3000)
        begin
            thou_c   = 4'd3;
            thou_sub = 12'd3000;
        end
        else if (value >= 12'd2000)
        begin
            thou_c   = 4'd2;
            thou_sub = 12'd2000;
        end
        else if (value >= 12'd1000)
        begin
            thou_c   = 4'd1;
            thou_sub = 12'd1000;
        end
        else
        begin
            thou_c   = 4'd0;
            thou_sub = 12'd0;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_valid_reg && !queue_full)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_status_reg <= status_c;
            s1_thou_reg   <= thou_c;
            s1_rem_reg    <= 10'(value - thou_sub);
        end
    end

    // hundreds and tens by parallel compares against the multiples
    always_comb
    begin
        hund_c = 4'd0;
        for (int k = 1; k < 10; k++)
        begin
            if (s1_rem_reg >= 10'(k * 100))
                hund_c = 4'(k);
        end
        rem_h = s1_rem_reg - (10'(hund_c) * 10'd100);
        rem_t = 7'(rem_h);

        tens_c = 4'd0;
        for (int k = 1; k < 10; k++)
        begin
            if (rem_t >= 7'(k * 10))
                tens_c = 4'(k);
        end
        tens_sub = 7'(tens_c) * 7'd10;
        unit_c   = 4'(rem_t - tens_sub);
    end

    always_comb
    begin
        push_item.status    = s1_status_reg;
        push_item.digits[0] = s1_thou_reg;
        push_item.digits[1] = hund_c;
        push_item.digits[2] = tens_c;
        push_item.digits[3] = unit_c;
    end

endmodule

### rtl/i2r_queue.sv
// ============================================================================
// i2r_queue: item queue between front and back
// Small circular buffer of classified items; head is visible while valid.
// ============================================================================
module i2r_queue
    import i2r_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  head_valid,
    output item_t head_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    item_t            entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = entries[rd_ptr_reg];
    assign do_push    = push_valid && !full;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries[wr_ptr_reg] <= push_item;
    end

endmodule

### rtl/i2r_back.sv
// ============================================================================
// i2r_back: character sequencer
// Walk the head item's places and pattern positions, one letter per cycle
// while the receiver does not stall, into the output register.
// ============================================================================
module i2r_back
    import i2r_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  item_t      head_item,
    output logic       pop,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output logic [6:0] symbol,
    output logic       last,
    output logic [1:0] status
);

    place_t     place_reg, place_next;
    pos_t       pos_reg, pos_next;
    logic       out_valid_reg, out_valid_next;
    logic [6:0] symbol_reg;
    logic       last_reg;
    status_t    status_reg;

    place_t     cur;
    logic       more;
    digit_t     d;
    logic       digit_done;
    logic [6:0] sym_c;
    logic       last_c;
    logic       item_done;
    logic       advance;

    // first nonzero place at or after the current one
    always_comb
    begin
        cur = place_reg;
        for (int p = 3; p >= 0; p--)
        begin
            if (2'(p) >= place_reg && head_item.digits[2'(p)] != 4'd0)
                cur = 2'(p);
        end
        more = 1'b0;
        for (int p = 0; p < 4; p++)
        begin
            if (2'(p) > cur && head_item.digits[2'(p)] != 4'd0)
                more = 1'b1;
        end
        d          = head_item.digits[cur];
        digit_done = ((3'(pos_reg) + 3'd1) == pattern_len(d));

        if (head_item.status != STATUS_OK)
        begin
            sym_c     = 7'd0;
            last_c    = 1'b1;
            item_done = 1'b1;
        end
        else
        begin
            sym_c     = place_letter(cur, pattern_sel(d, pos_reg));
            last_c    = digit_done && !more;
            item_done = last_c;
        end
    end

    assign advance = head_valid && (!out_valid_reg || !rsp_stall);
    assign pop     = advance && item_done;

    always_comb
    begin
        place_next     = place_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        if (advance)
        begin
            out_valid_next = 1'b1;
            if (item_done)
            begin
                place_next = '0;
                pos_next   = '0;
            end
            else if (digit_done)
            begin
                place_next = cur + 1'b1;
                pos_next   = '0;
            end
            else
            begin
                place_next = cur;
                pos_next   = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            place_reg     <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            place_reg     <= place_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            symbol_reg <= sym_c;
            last_reg   <= last_c;
            status_reg <= head_item.status;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign symbol    = symbol_reg;
    assign last      = last_reg;
    assign status    = status_reg;

endmodule

### rtl/integer_to_roman_numeral.sv
// ============================================================================
// integer_to_roman_numeral: binary integer to Roman numeral characters
// Request channel takes a 12-bit value; response channel emits one ASCII
// letter per word, most significant place first, last flag on the final one.
// ============================================================================
//
// Usage:
//   - req_valid/req_stall/value: one integer per word. 1..3999 are spelled
//     out; 0 gives a single word with status empty; 4000..4095 give a single
//     word with status out of range. Symbol is 0 on those.
//   - rsp_valid/rsp_stall/symbol/last/status: one character per word.
//   - Path: the first character of a value goes from the front register
//     through the queue to the output register.
//   - Throughput: the character sequencer emits one word per cycle while
//     the receiver does not stall; a value has 1 to 15 characters (3888 is
//     the longest). The request side keeps accepting one value per cycle
//     until the queue of QUEUE_DEPTH items and the front register fill.
//   - When the receiver stalls, the output register holds its word and the
//     sequencer waits; the front keeps filling the queue independently.
//   - Reset (rst_n low, asynchronous) empties the front register and queue
//     and drops any partly emitted value.
//
module integer_to_roman_numeral
    import i2r_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [11:0] value,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [6:0]  symbol,
    output logic        last,
    output logic [1:0]  status
);

    // front to queue
    logic  push_valid;
    item_t push_item;
    logic  queue_full;

    // queue to back
    logic  head_valid;
    item_t head_item;
    logic  pop;

    // classify the value and split it into decimal places
    i2r_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .value      (value),
        .push_valid (push_valid),
        .push_item  (push_item),
        .queue_full (queue_full)
    );

    // decouple the one-per-cycle front (stalled while the queue is full) from the multi-cycle back
    i2r_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    // spell the head item one letter per cycle while rsp_stall is low
    i2r_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .symbol     (symbol),
        .last       (last),
        .status     (status)
    );

endmodule
